/* src/psts_pkg.sv */
// ----------------------------------------------------------------------------
// psts_pkg: shared types and constants for the peak sort / threshold select
// Field widths, register indexes, status codes, FSM states and the
// controller-datapath command and status groups.
// ----------------------------------------------------------------------------
package psts_pkg;

  localparam int MAX_PEAKS_DEF = 1024;

  localparam int COORD_W  = 24;
  localparam int AMP_W    = 32;
  localparam int SELCNT_W = 11;
  localparam int RIDX_W   = 10;
  localparam int STAT_W   = 3;
  localparam int PCT_W    = 7;
  localparam int MINPK_W  = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 128;

  localparam int MIN_PEAKS_RST = 201;
  localparam int KEEP_PCT_RST  = 50;
  localparam int PCT_FULL      = 100;
  localparam int MIN_POSITIVE  = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_OFFSET  = 3'd0,
    REG_Y_OFFSET  = 3'd1,
    REG_THR_MODE  = 3'd2,
    REG_ABS_THR   = 3'd3,
    REG_KEEP_PCT  = 3'd4,
    REG_MIN_PEAKS = 3'd5
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_FEW_PEAKS  = 3'd1,
    STAT_FEW_POS    = 3'd2,
    STAT_NONE_SEL   = 3'd3,
    STAT_NOT_SORTED = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_OUT,
    S_SORT0,
    S_SORT_LD,
    S_SORT_CMP,
    S_SORT_WL,
    S_P_INIT,
    S_P_RD,
    S_P_CHK,
    S_SEL,
    S_A_RD,
    S_A_CHK,
    S_MUL,
    S_QUO,
    S_THR_RD,
    S_THR_LD,
    S_FIN,
    S_EMIT
  } psts_state_t;

  typedef struct packed {
    logic signed [AMP_W-1:0]   amp;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } peak_t;

  typedef struct packed {
    logic do_load;
    logic rd_req;
    logic out_rd;
    logic out_sel;
    logic sort_init;
    logic carry_ld;
    logic sort_cmp;
    logic sort_wlast;
    logic scan_init;
    logic scan_rd;
    logic pos_step;
    logic sel_eval;
    logic abs_step;
    logic div_mul;
    logic div_q;
    logic thr_rd;
    logic thr_ld;
    logic fin;
  } psts_cmd_t;

  typedef struct packed {
    logic n_le1;
    logic n_zero;
    logic sort_last;
    logic swapped;
    logic amp_pos;
    logic i_next_lt_n;
    logic sel_err;
    logic rel_mode;
    logic abs_in_range;
    logic amp_ge;
    logic out_valid;
  } psts_stat_t;

endpackage

/* src/psts_ctrl.sv */
// ----------------------------------------------------------------------------
// psts_ctrl: sequencing controller
// Handshake decode and the state machine that steps the datapath through
// load, read, bubble sort passes, positive scan and selection.
// ----------------------------------------------------------------------------
module psts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  psts_pkg::psts_stat_t  stat,
  output psts_pkg::psts_cmd_t   cmd
);
  import psts_pkg::*;

  psts_state_t state_r, state_nxt;
  logic        acc;

  assign in_tready = (state_r == S_IDLE) && !stat.out_valid;
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_tuser == OP_READ) state_nxt = S_RD_OUT;
          else if (in_tlast)       state_nxt = S_SORT0;
        end
      end
      S_RD_OUT:   state_nxt = S_IDLE;
      S_SORT0:    state_nxt = stat.n_le1 ? S_P_INIT : S_SORT_LD;
      S_SORT_LD:  state_nxt = S_SORT_CMP;
      S_SORT_CMP: state_nxt = stat.sort_last ? S_SORT_WL : S_SORT_CMP;
      S_SORT_WL:  state_nxt = stat.swapped ? S_SORT0 : S_P_INIT;
      S_P_INIT:   state_nxt = stat.n_zero ? S_SEL : S_P_RD;
      S_P_RD:     state_nxt = S_P_CHK;
      S_P_CHK:    state_nxt = (stat.amp_pos && stat.i_next_lt_n) ? S_P_RD : S_SEL;
      S_SEL: begin
        if (stat.sel_err)       state_nxt = S_EMIT;
        else if (stat.rel_mode) state_nxt = S_MUL;
        else                    state_nxt = S_A_RD;
      end
      S_A_RD:     state_nxt = stat.abs_in_range ? S_A_CHK : S_FIN;
      S_A_CHK:    state_nxt = stat.amp_ge ? S_A_RD : S_FIN;
      S_MUL:      state_nxt = S_QUO;
      S_QUO:      state_nxt = S_THR_RD;
      S_THR_RD:   state_nxt = S_THR_LD;
      S_THR_LD:   state_nxt = S_FIN;
      S_FIN:      state_nxt = S_EMIT;
      S_EMIT:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.do_load = acc && (in_tuser == OP_LOAD);
        cmd.rd_req  = acc && (in_tuser == OP_READ);
      end
      S_RD_OUT:   cmd.out_rd     = 1'b1;
      S_SORT0:    cmd.sort_init  = 1'b1;
      S_SORT_LD:  cmd.carry_ld   = 1'b1;
      S_SORT_CMP: cmd.sort_cmp   = 1'b1;
      S_SORT_WL:  cmd.sort_wlast = 1'b1;
      S_P_INIT:   cmd.scan_init  = 1'b1;
      S_P_RD:     cmd.scan_rd    = 1'b1;
      S_P_CHK:    cmd.pos_step   = 1'b1;
      S_SEL:      cmd.sel_eval   = 1'b1;
      S_A_RD:     cmd.scan_rd    = 1'b1;
      S_A_CHK:    cmd.abs_step   = 1'b1;
      S_MUL:      cmd.div_mul    = 1'b1;
      S_QUO:      cmd.div_q      = 1'b1;
      S_THR_RD:   cmd.thr_rd     = 1'b1;
      S_THR_LD:   cmd.thr_ld     = 1'b1;
      S_FIN:      cmd.fin        = 1'b1;
      S_EMIT:     cmd.out_sel    = 1'b1;
      default:    cmd            = '0;
    endcase
  end

endmodule

/* src/psts_dp.sv */
// ----------------------------------------------------------------------------
// psts_dp: datapath
// Config registers, peak memory, sort carry register, scan counters,
// percent divider and the output register.
// ----------------------------------------------------------------------------
module psts_dp #(
  parameter int MAX_PEAKS = psts_pkg::MAX_PEAKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [psts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psts_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic [psts_pkg::IN_DATA_W-1:0]       in_tdata,
  input  psts_pkg::psts_cmd_t                  cmd,
  output psts_pkg::psts_stat_t                 stat,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [psts_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import psts_pkg::*;

  localparam int AW   = $clog2(MAX_PEAKS);
  localparam int CW   = $clog2(MAX_PEAKS + 1);
  localparam int MW   = (CW > MINPK_W) ? CW : MINPK_W;
  localparam int RXW  = (CW > RIDX_W) ? CW : RIDX_W;
  localparam int PW   = CW + PCT_W;
  localparam int SH   = PW + 7;
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'd99) / 64'd100;
  localparam int RW   = $clog2(RECIP64 + 64'd1);
  localparam int PEAK_W = $bits(peak_t);

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1])
      sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    else
      sat_add = s[COORD_W-1:0];
  endfunction

  // input fields
  logic [COORD_W-1:0] f_x, f_y;
  logic [AMP_W-1:0]   f_amp;
  logic [RIDX_W-1:0]  f_idx;
  assign f_x   = in_tdata[23:0];
  assign f_y   = in_tdata[47:24];
  assign f_amp = in_tdata[79:48];
  assign f_idx = in_tdata[89:80];

  // config
  logic [COORD_W-1:0] x_off_r, y_off_r;
  logic               thr_mode_r;
  logic [AMP_W-1:0]   abs_thr_r;
  logic [PCT_W-1:0]   keep_pct_r;
  logic [MINPK_W-1:0] min_peaks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r     <= '0;
      y_off_r     <= '0;
      thr_mode_r  <= 1'b0;
      abs_thr_r   <= '0;
      keep_pct_r  <= PCT_W'(KEEP_PCT_RST);
      min_peaks_r <= MINPK_W'(MIN_PEAKS_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_OFFSET:  x_off_r     <= cfg_data[COORD_W-1:0];
        REG_Y_OFFSET:  y_off_r     <= cfg_data[COORD_W-1:0];
        REG_THR_MODE:  thr_mode_r  <= cfg_data[0];
        REG_ABS_THR:   abs_thr_r   <= cfg_data[AMP_W-1:0];
        REG_KEEP_PCT:  keep_pct_r  <= cfg_data[PCT_W-1:0];
        REG_MIN_PEAKS: min_peaks_r <= cfg_data[MINPK_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [CW-1:0]   n_r, chosen_cnt_r, j_r, i_r, p_r, k_r;
  logic            closed_r, swapped_r, rd_hit_r;
  status_t         run_stat_r;
  logic [AMP_W-1:0] chosen_thr_r;
  peak_t           carry_r, rd_q;
  logic [PW-1:0]   prod_r;

  logic [PEAK_W-1:0] mem [MAX_PEAKS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  peak_t             mem_wdata;

  logic [CW-1:0] n_base, sel_r_idx;
  logic          room;
  logic [PCT_W-1:0] pct;
  logic [PW+RW-1:0] quo_full;
  logic          carry_lt;

  assign n_base   = closed_r ? '0 : n_r;
  assign room     = n_base < CW'(MAX_PEAKS);
  assign pct      = (keep_pct_r > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : keep_pct_r;
  assign quo_full = prod_r * RW'(RECIP64);
  assign sel_r_idx = (k_r >= n_r) ? (n_r - CW'(1)) : k_r;
  assign carry_lt = $signed(carry_r.amp) < $signed(rd_q.amp);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = carry_r;
    if (cmd.do_load) begin
      mem_we      = room;
      mem_waddr   = n_base[AW-1:0];
      mem_wdata.x = sat_add(f_x, x_off_r);
      mem_wdata.y = sat_add(f_y, y_off_r);
      mem_wdata.amp = f_amp;
    end else if (cmd.sort_cmp) begin
      mem_we    = 1'b1;
      mem_waddr = j_r[AW-1:0];
      mem_wdata = carry_lt ? rd_q : carry_r;
    end else if (cmd.sort_wlast) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(n_r - CW'(1));
    end
  end

  always_comb begin
    mem_raddr = '0;
    if (cmd.rd_req)        mem_raddr = AW'(f_idx);
    else if (cmd.carry_ld) mem_raddr = AW'(1);
    else if (cmd.sort_cmp) mem_raddr = AW'(j_r + CW'(2));
    else if (cmd.scan_rd)  mem_raddr = i_r[AW-1:0];
    else if (cmd.thr_rd)   mem_raddr = sel_r_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // sort and scan registers
  always_ff @(posedge clk) begin
    if (cmd.carry_ld) begin
      carry_r <= rd_q;
      j_r     <= '0;
    end
    if (cmd.sort_cmp) begin
      j_r <= j_r + CW'(1);
      if (!carry_lt) carry_r <= rd_q;
    end
    if (cmd.sort_init) swapped_r <= 1'b0;
    else if (cmd.sort_cmp && carry_lt) swapped_r <= 1'b1;
    if (cmd.scan_init) begin
      i_r <= '0;
      p_r <= '0;
    end
    if (cmd.pos_step && stat.amp_pos) begin
      i_r <= i_r + CW'(1);
      p_r <= p_r + CW'(1);
    end
    if (cmd.sel_eval) begin
      i_r <= '0;
      k_r <= '0;
    end
    if (cmd.abs_step && stat.amp_ge) begin
      i_r <= i_r + CW'(1);
      k_r <= k_r + CW'(1);
    end
    if (cmd.div_mul) prod_r <= PW'(p_r) * PW'(pct);
    if (cmd.div_q)   k_r    <= CW'(quo_full >> SH);
    if (cmd.rd_req)  rd_hit_r <= RXW'(f_idx) < RXW'(n_r);
  end

  // list and result state; a load with tlast closes the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= '0;
      closed_r     <= 1'b0;
      run_stat_r   <= STAT_NOT_SORTED;
      chosen_cnt_r <= '0;
      chosen_thr_r <= '0;
    end else begin
      if (cmd.do_load) begin
        n_r        <= room ? (n_base + CW'(1)) : n_base;
        closed_r   <= in_tdata[IN_DATA_W-1];
        run_stat_r <= STAT_NOT_SORTED;
      end
      if (cmd.sel_eval) begin
        chosen_cnt_r <= '0;
        chosen_thr_r <= thr_mode_r ? '0 : abs_thr_r;
        if (MW'(n_r) < MW'(min_peaks_r))       run_stat_r <= STAT_FEW_PEAKS;
        else if (p_r < CW'(MIN_POSITIVE))     run_stat_r <= STAT_FEW_POS;
      end
      if (cmd.thr_ld) chosen_thr_r <= rd_q.amp;
      if (cmd.fin) begin
        chosen_cnt_r <= k_r;
        run_stat_r   <= (k_r == '0) ? STAT_NONE_SEL : STAT_OK;
      end
    end
  end

  // output register
  logic                 out_valid_r;
  logic [COORD_W-1:0]   o_x_r, o_y_r;
  logic [AMP_W-1:0]     o_amp_r, o_thr_r;
  logic [SELCNT_W-1:0]  o_cnt_r;
  status_t              o_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_rd || cmd.out_sel) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_rd || cmd.out_sel) begin
      o_x_r    <= '0;
      o_y_r    <= '0;
      o_amp_r  <= '0;
      o_cnt_r  <= SELCNT_W'(chosen_cnt_r);
      o_thr_r  <= chosen_thr_r;
      o_stat_r <= run_stat_r;
      if (cmd.out_rd && run_stat_r == STAT_NOT_SORTED) begin
        o_cnt_r <= '0;
        o_thr_r <= '0;
      end else if (cmd.out_rd && rd_hit_r) begin
        o_x_r   <= rd_q.x;
        o_y_r   <= rd_q.y;
        o_amp_r <= rd_q.amp;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_stat_r, o_thr_r, o_cnt_r, o_amp_r, o_y_r, o_x_r};

  assign stat.n_le1        = n_r <= CW'(1);
  assign stat.n_zero       = n_r == '0;
  assign stat.sort_last    = (j_r + CW'(2)) == n_r;
  assign stat.swapped      = swapped_r;
  assign stat.amp_pos      = $signed(rd_q.amp) > 0;
  assign stat.i_next_lt_n  = (i_r + CW'(1)) < n_r;
  assign stat.sel_err      = (MW'(n_r) < MW'(min_peaks_r)) || (p_r < CW'(MIN_POSITIVE));
  assign stat.rel_mode     = thr_mode_r;
  assign stat.abs_in_range = i_r < p_r;
  assign stat.amp_ge       = $signed(rd_q.amp) >= $signed(abs_thr_r);
  assign stat.out_valid    = out_valid_r;

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_PEAKS))
    else $error("loaded count above capacity");
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (run_stat_r == STAT_OK) |-> (chosen_cnt_r != '0))
    else $error("ok status with empty selection");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_rd || cmd.out_sel) |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");
  a_sort_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sort_cmp |-> (n_r > CW'(1)))
    else $error("compare step on short list");
`endif

endmodule

/* src/peak_sort_threshold_select_core.sv */
// ----------------------------------------------------------------------------
// peak_sort_threshold_select_core: peak list sorter with threshold select
// Top level: stream ports, config write port, controller and datapath.
// ----------------------------------------------------------------------------
// Load items (tuser = 0) store one peak each, with the x/y offsets added and
// saturated, at one item per cycle while the block is idle and no result
// waits. The load carrying tlast closes the list and starts a bubble sort by
// amplitude, descending and stable: each pass walks the list once through
// the peak memory (one read and one write per cycle) at one compare per
// cycle, and passes repeat until one makes no swap. A positive scan (one read
// and check per positive peak) and the selection (absolute: one read and
// check per selected peak; relative: multiply, quotient, threshold read and
// load) follow, then one result item with zeros in x/y/amp and the count,
// threshold and status. Read items (tuser = 1) return the peak at
// read_index. Input is held off while a sort runs and while a result waits.
// No clearing pass follows reset.
module peak_sort_threshold_select_core #(
  parameter int MAX_PEAKS = psts_pkg::MAX_PEAKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psts_pkg::CFG_DAT_W-1:0]    cfg_data,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_x[23:0], in_y[47:24], in_amp[79:48], read_index[89:80], zero pad
  input  logic [psts_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,  // op: 0 load, 1 read
  input  logic                              in_tlast,  // load_last
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_x[23:0], out_y[47:24], out_amp[79:48], selected_count[90:80],
  // threshold_used[122:91], status[125:123], zero pad
  output logic [psts_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import psts_pkg::*;

  psts_cmd_t  cmd;
  psts_stat_t stat;
  logic [IN_DATA_W-1:0] dp_in;

  // registers accept every cycle
  assign cfg_ready = 1'b1;

  // tlast rides along in the unused top bit so the datapath sees one word
  assign dp_in = {in_tlast, in_tdata[IN_DATA_W-2:0]};

  psts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  psts_dp #(
    .MAX_PEAKS (MAX_PEAKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (dp_in),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* bench/tb_peak_sort_threshold_select_core.sv */
// ----------------------------------------------------------------------------
// tb_peak_sort_threshold_select_core: regression for the peak sorter
// Loads peak lists, checks the sort/select result item and the ranked reads
// against an in-bench model of the block, over several register settings,
// with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_peak_sort_threshold_select_core;
  import psts_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DAT_W-1:0]   cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;

  peak_sort_threshold_select_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // one expected result item
  typedef struct {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [AMP_W-1:0]    amp;
    logic [SELCNT_W-1:0]        sel;
    logic signed [AMP_W-1:0]    thr;
    logic [STAT_W-1:0]          stat;
  } peak_result_t;

  peak_result_t pending_results[$];

  // ---- shadow of the block: peak store, list state, registers ----
  logic signed [COORD_W-1:0] pk_x   [MAX_PEAKS_DEF];
  logic signed [COORD_W-1:0] pk_y   [MAX_PEAKS_DEF];
  logic signed [AMP_W-1:0]   pk_amp [MAX_PEAKS_DEF];
  int                        n_loaded;
  bit                        list_done;    // next load opens a new list
  logic [SELCNT_W-1:0]       chosen_n;
  logic signed [AMP_W-1:0]   chosen_thr;
  status_t                   run_stat;

  logic signed [COORD_W-1:0] x_off;
  logic signed [COORD_W-1:0] y_off;
  logic                      rel_mode;
  logic signed [AMP_W-1:0]   abs_thr;
  logic [PCT_W-1:0]          keep_pct;
  logic [MINPK_W-1:0]        min_pk;

  // bookkeeping
  int  errors;
  int  items_sent;
  int  results_seen;
  int  lists_closed;
  int  cycles;
  bit  gaps_on;
  int  out_stall;

  // ---- clock ----
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("peak_sort_threshold_select_core regression: fail");
      $finish;
    end
  end

  // ---- model ----
  function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[COORD_W-1:0];
  endfunction

  // stable descending sort, then positive count and selection
  task automatic sort_and_select();
    int i, j, p, k, r, pct;
    logic signed [COORD_W-1:0] hx, hy;
    logic signed [AMP_W-1:0]   ha;
    for (i = 1; i < n_loaded; i++) begin
      hx = pk_x[i]; hy = pk_y[i]; ha = pk_amp[i];
      j = i;
      while (j > 0 && pk_amp[j-1] < ha) begin
        pk_x[j] = pk_x[j-1]; pk_y[j] = pk_y[j-1]; pk_amp[j] = pk_amp[j-1];
        j--;
      end
      pk_x[j] = hx; pk_y[j] = hy; pk_amp[j] = ha;
    end
    p = 0;
    while (p < n_loaded && pk_amp[p] > 0) p++;
    chosen_n   = '0;
    chosen_thr = rel_mode ? '0 : abs_thr;
    if (n_loaded < int'(min_pk)) begin
      run_stat = STAT_FEW_PEAKS;
    end else if (p < MIN_POSITIVE) begin
      run_stat = STAT_FEW_POS;
    end else begin
      if (!rel_mode) begin
        k = 0;
        while (k < p && pk_amp[k] >= abs_thr) k++;
      end else begin
        pct = (keep_pct > PCT_FULL) ? PCT_FULL : int'(keep_pct);
        k = (p * pct) / PCT_FULL;
        r = (k >= n_loaded) ? n_loaded - 1 : k;
        chosen_thr = pk_amp[r];
      end
      chosen_n = k[SELCNT_W-1:0];
      run_stat = (k == 0) ? STAT_NONE_SEL : STAT_OK;
    end
  endtask

  task automatic model_item(bit op, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y,
                            logic signed [AMP_W-1:0] amp, bit last,
                            logic [RIDX_W-1:0] ridx);
    peak_result_t e;
    e = '{x: '0, y: '0, amp: '0, sel: '0, thr: '0, stat: STAT_NOT_SORTED};
    if (op == OP_LOAD) begin
      if (list_done) begin
        n_loaded  = 0;
        list_done = 1'b0;
      end
      run_stat = STAT_NOT_SORTED;
      if (n_loaded < MAX_PEAKS_DEF) begin
        pk_x[n_loaded]   = clamp_coord(int'(x) + int'(x_off));
        pk_y[n_loaded]   = clamp_coord(int'(y) + int'(y_off));
        pk_amp[n_loaded] = amp;
        n_loaded++;
      end
      if (!last) return;
      list_done = 1'b1;
      lists_closed++;
      sort_and_select();
    end else if (run_stat != STAT_NOT_SORTED) begin
      if (int'(ridx) < n_loaded) begin
        e.x = pk_x[ridx]; e.y = pk_y[ridx]; e.amp = pk_amp[ridx];
      end
    end else begin
      pending_results.push_back(e);
      return;
    end
    e.sel  = chosen_n;
    e.thr  = chosen_thr;
    e.stat = run_stat;
    pending_results.push_back(e);
  endtask

  // ---- result side: random stall bursts ----
  always @(negedge clk) begin
    if (!gaps_on) begin
      out_tready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      out_stall  <= $urandom_range(1, 19) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic cmp_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    peak_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none actual %h", $time,
                 out_tdata);
      end else begin
        e = pending_results.pop_front();
        cmp_field("out_x", e.x, $signed(out_tdata[23:0]));
        cmp_field("out_y", e.y, $signed(out_tdata[47:24]));
        cmp_field("out_amp", e.amp, $signed(out_tdata[79:48]));
        cmp_field("selected_count", e.sel, out_tdata[90:80]);
        cmp_field("threshold_used", e.thr, $signed(out_tdata[122:91]));
        cmp_field("status", e.stat, out_tdata[125:123]);
      end
    end
  end

  // ---- driver tasks; each returns just after a falling edge ----
  task automatic send_item(bit op, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y,
                           logic signed [AMP_W-1:0] amp, bit last,
                           logic [RIDX_W-1:0] ridx);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tlast  = last;
    in_tdata  = {6'b0, ridx, amp, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_item(op, x, y, amp, last, ridx);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_peak(logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y,
                           logic signed [AMP_W-1:0] amp, bit last);
    send_item(OP_LOAD, x, y, amp, last, RIDX_W'($urandom));
  endtask

  task automatic read_peak(logic [RIDX_W-1:0] ridx);
    send_item(OP_READ, COORD_W'($urandom), COORD_W'($urandom), $urandom,
              1'($urandom), ridx);
  endtask

  // hold the sender until every expected item is back, then let the
  // block settle (a plain load leaves no result to wait on)
  task automatic wait_drained(int settle);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] val);
    wait_drained(8);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_OFFSET:  x_off    = val[COORD_W-1:0];
      REG_Y_OFFSET:  y_off    = val[COORD_W-1:0];
      REG_THR_MODE:  rel_mode = val[0];
      REG_ABS_THR:   abs_thr  = val;
      REG_KEEP_PCT:  keep_pct = val[PCT_W-1:0];
      REG_MIN_PEAKS: min_pk   = val[MINPK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [AMP_W-1:0] pick_amp(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) - 4;     // ties and non-positive
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // one list of n peaks, random content; occasionally a read lands mid-list
  task automatic load_list(int n, int kind);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 60) == 0) read_peak(RIDX_W'($urandom));
      load_peak(COORD_W'($urandom), COORD_W'($urandom), pick_amp(kind), i == n - 1);
    end
  endtask

  // ---- tests ----
  task automatic test_reset_defaults();
    // reads before any sort, then a short list under reset registers
    read_peak('0);
    read_peak('1);
    load_peak(24'sd100, -24'sd100, 32'sd5, 1'b0);
    load_peak(24'sd1, 24'sd2, 32'sd7, 1'b0);
    load_peak(24'sd3, 24'sd4, -32'sd2, 1'b1);
    read_peak(10'd0);
    read_peak(10'd2);
  endtask

  task automatic test_field_extremes();
    write_reg(REG_X_OFFSET, 32'h007F_FFFF);
    write_reg(REG_Y_OFFSET, 32'h0080_0000);
    write_reg(REG_MIN_PEAKS, 32'd0);
    write_reg(REG_THR_MODE, 32'd0);
    write_reg(REG_ABS_THR, 32'd0);
    // saturation both ways, amplitude extremes, equal amplitudes for stability
    load_peak(24'sh7FFFFF, 24'sh800000, 32'sh7FFF_FFFF, 1'b0);
    load_peak(24'sh800000, 24'sh7FFFFF, 32'sh8000_0000, 1'b0);
    load_peak(24'sd10, 24'sd20, 32'sd0, 1'b0);
    load_peak(24'sd11, 24'sd21, 32'sd1, 1'b0);
    load_peak(24'sd12, 24'sd22, 32'sd1, 1'b0);
    load_peak(24'sd13, 24'sd23, -32'sd1, 1'b1);
    for (int i = 0; i < 7; i++) read_peak(RIDX_W'(i));
    read_peak(10'h3FF);
    // a load reopens the list: reads report not sorted
    load_peak(24'sd0, 24'sd0, 32'sd9, 1'b0);
    read_peak(10'd0);
    load_peak(24'sd0, 24'sd0, 32'sd8, 1'b1);
    read_peak(10'd1);
  endtask

  task automatic test_status_cases();
    write_reg(REG_X_OFFSET, 32'd0);
    write_reg(REG_Y_OFFSET, 32'hFFFF_FF00);
    write_reg(REG_MIN_PEAKS, 32'd5);
    load_list(3, 2);                    // too few peaks
    write_reg(REG_MIN_PEAKS, 32'd1);
    load_peak(24'sd1, 24'sd1, 32'sd50, 1'b1);   // single peak: too few positive
    write_reg(REG_ABS_THR, 32'h7FFF_FFFF);
    load_list(6, 2);                    // nothing reaches the threshold
    write_reg(REG_ABS_THR, 32'h8000_0000);
    load_list(6, 0);
    write_reg(REG_THR_MODE, 32'd1);
    write_reg(REG_KEEP_PCT, 32'd0);
    load_list(5, 2);                    // relative, keep nothing
    write_reg(REG_KEEP_PCT, 32'd100);
    load_list(5, 2);                    // all positive: rank clamps to n-1
    read_peak(10'd4);
    write_reg(REG_KEEP_PCT, 32'd127);   // above range, acts as full
    load_list(8, 1);
    read_peak(10'd0);
  endtask

  task automatic test_full_list();
    // descending amplitudes keep the sort to one pass; extra loads are dropped,
    // the last of them still closes the list
    write_reg(REG_MIN_PEAKS, 32'd1024);
    write_reg(REG_KEEP_PCT, 32'd37);
    for (int i = 0; i < MAX_PEAKS_DEF + 6; i++)
      load_peak(COORD_W'($urandom), COORD_W'($urandom), 32'sd2000 - i,
                i == MAX_PEAKS_DEF + 5);
    read_peak(10'd0);
    read_peak(10'd1023);
    read_peak(10'd512);
  endtask

  task automatic test_random_lists();
    int n, kind, nreads;
    while (items_sent < 1400) begin
      if (items_sent > 1200) gaps_on = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 5))
            0: write_reg(REG_X_OFFSET, $urandom_range(0, 1) ? $urandom
                                                         : $urandom_range(0, 2000));
            1: write_reg(REG_Y_OFFSET, $urandom_range(0, 1) ? $urandom
                                                         : 32'hFFFF_F000);
            2: write_reg(REG_THR_MODE, $urandom_range(0, 1));
            3: write_reg(REG_ABS_THR, $urandom_range(0, 1) ? $urandom
                                                        : $urandom_range(0, 900));
            4: write_reg(REG_KEEP_PCT, $urandom_range(0, 100));
            default: write_reg(REG_MIN_PEAKS, $urandom_range(0, 30));
          endcase
        end
      end
      n    = ($urandom_range(0, 24) == 0) ? $urandom_range(180, 240)
                                          : $urandom_range(1, 40);
      kind = $urandom_range(0, 2);
      load_list(n, kind);
      nreads = $urandom_range(0, n + 4);
      for (int i = 0; i < nreads; i++)
        read_peak(RIDX_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                      : $urandom_range(0, n - 1)));
      if ($urandom_range(0, 7) == 0) wait_drained(0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_tvalid = 1'b0; in_tuser = 1'b0; in_tlast = 1'b0; in_tdata = '0;
    out_tready = 1'b0;
    out_stall = 0;
    errors = 0; items_sent = 0; results_seen = 0; lists_closed = 0; cycles = 0;
    gaps_on = 1'b1;
    n_loaded = 0; list_done = 1'b0; chosen_n = '0; chosen_thr = '0;
    run_stat = STAT_NOT_SORTED;
    x_off = '0; y_off = '0; rel_mode = 1'b0; abs_thr = '0;
    keep_pct = PCT_W'(KEEP_PCT_RST); min_pk = MINPK_W'(MIN_PEAKS_RST);
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_status_cases();
    test_full_list();
    test_random_lists();

    wait_drained(50);
    $display("covered %0d items, %0d results, %0d closed lists incl. full store",
             items_sent, results_seen, lists_closed);
    $display("both threshold modes, all status codes, register extremes, %0d errors",
             errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("peak_sort_threshold_select_core regression: pass");
    end else begin
      $display("peak_sort_threshold_select_core regression: fail");
    end
    $finish;
  end

endmodule
